### hdl/primary_power_source_select_unit_defines.svh
// Assertion macros used by the checker file of the power source selector.
`ifndef PRIMARY_POWER_SOURCE_SELECT_UNIT_DEFINES_SVH
`define PRIMARY_POWER_SOURCE_SELECT_UNIT_DEFINES_SVH

// Implication checked in the same cycle, idle during reset.
`define PPSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppss check failed");

// Implication checked in the following cycle, idle during reset.
`define PPSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppss check failed");

// Delayed implication, idle during reset.
`define PPSS_ASSERT_LAT2(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> ##2 (cons)) \
        else $error("ppss check failed");

`endif

### hdl/ppss_pkg.sv
// Types, constants and a helper function of the power source selector.
`timescale 1ns / 1ps

package ppss_pkg;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ICON_POLICY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGING    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPS         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_POWER  = 3'd5;

    // Icon policy codes.
    localparam logic [1:0] POLICY_PRESENT = 2'd0;
    localparam logic [1:0] POLICY_ACTIVE  = 2'd1;
    localparam logic [1:0] POLICY_NEVER   = 2'd2;

    // Kind weights used by the ranking.
    localparam logic [1:0] WEIGHT_LINE    = 2'd0;
    localparam logic [1:0] WEIGHT_OTHER   = 2'd1;
    localparam logic [1:0] WEIGHT_BATTERY = 2'd2;

    localparam logic [6:0] LEVEL_MAX   = 7'd100;
    localparam logic [15:0] LEVEL_HALF = 16'd128;

    typedef struct packed {
        logic [1:0] icon_policy;
        logic [3:0] charging_code;
        logic [3:0] discharging_code;
        logic [4:0] battery_kind_code;
        logic [4:0] ups_kind_code;
        logic [4:0] line_power_kind_code;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        icon_policy:          2'd0,
        charging_code:        4'd1,
        discharging_code:     4'd2,
        battery_kind_code:    5'd2,
        ups_kind_code:        5'd3,
        line_power_kind_code: 5'd1
    };

    typedef struct packed {
        logic [14:0] level;
        logic [31:0] time_est;
        logic [4:0]  kind;
        logic [3:0]  state;
    } dev_t;

    typedef struct packed {
        logic       primary_valid;
        logic [3:0] primary_index;
        logic [6:0] level_percent;
        logic       icon_visible;
        logic [4:0] battery_count;
        logic [4:0] active_count;
    } result_t;

    function automatic logic [1:0] kind_weight(input logic [4:0] kind, input cfg_t cfg);
        logic [1:0] w;
        if (kind == cfg.line_power_kind_code) begin
            w = WEIGHT_LINE;
        end else if (kind == cfg.battery_kind_code) begin
            w = WEIGHT_BATTERY;
        end else begin
            w = WEIGHT_OTHER;
        end
        return w;
    endfunction

endpackage

### hdl/ppss_rank.sv
// Comparator that tells whether a new device record ranks ahead of the held one.
`timescale 1ns / 1ps

module ppss_rank (
    input  ppss_pkg::cfg_t cfg,
    input  ppss_pkg::dev_t new_dev,
    input  ppss_pkg::dev_t held_dev,
    output logic           ahead
);
    import ppss_pkg::*;

    logic       nd, hd, nc, hc;
    logic       n_known, h_known;
    logic [1:0] wn, wh;

    assign nd      = (new_dev.state == cfg.discharging_code);
    assign hd      = (held_dev.state == cfg.discharging_code);
    assign nc      = (new_dev.state == cfg.charging_code);
    assign hc      = (held_dev.state == cfg.charging_code);
    assign n_known = (new_dev.time_est != 32'd0);
    assign h_known = (held_dev.time_est != 32'd0);
    assign wn      = kind_weight(new_dev.kind, cfg);
    assign wh      = kind_weight(held_dev.kind, cfg);

    // Discharging first, then charging with a known time, then weight and state.
    always_comb begin
        if (nd || hd) begin
            if (!nd) begin
                ahead = 1'b0;
            end else if (!hd) begin
                ahead = 1'b1;
            end else if (!n_known || !h_known) begin
                ahead = n_known;
            end else if (new_dev.time_est != held_dev.time_est) begin
                ahead = (new_dev.time_est < held_dev.time_est);
            end else begin
                ahead = (new_dev.level < held_dev.level);
            end
        end else if ((nc && n_known) || (hc && h_known)) begin
            if (!nc) begin
                ahead = 1'b0;
            end else if (!hc) begin
                ahead = 1'b1;
            end else if (!n_known || !h_known) begin
                ahead = n_known;
            end else if (new_dev.time_est != held_dev.time_est) begin
                ahead = (new_dev.time_est > held_dev.time_est);
            end else begin
                ahead = (new_dev.level < held_dev.level);
            end
        end else if (wn != wh) begin
            ahead = (wn > wh);
        end else begin
            ahead = (new_dev.state < held_dev.state);
        end
    end

endmodule

### hdl/ppss_track.sv
// Running list state: best device so far, tallies and the end-of-list result.
`timescale 1ns / 1ps

module ppss_track #(
    parameter int MAX_DEVICES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ppss_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic              present,
    input  logic              last,
    input  ppss_pkg::dev_t    dev,
    output ppss_pkg::result_t result
);
    import ppss_pkg::*;

    localparam int PW  = $clog2(MAX_DEVICES + 1);
    localparam int BPW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    logic           have_reg, have_next, have_upd;
    logic [BPW-1:0] best_pos_reg, best_pos_next, best_pos_upd;
    dev_t           best_reg, best_next, best_upd;
    logic [PW-1:0]  pos_reg, pos_next, pos_upd;
    logic [PW-1:0]  batt_reg, batt_next, batt_upd;
    logic [PW-1:0]  act_reg, act_next, act_upd;

    logic           ahead;
    logic           take;
    logic           is_batt, is_active;
    logic [15:0]    level_round;
    logic [7:0]     level_full;
    logic [BPW+3:0] pos_ext;
    logic [PW+4:0]  batt_ext, act_ext;

    ppss_rank u_rank (
        .cfg      (cfg),
        .new_dev  (dev),
        .held_dev (best_reg),
        .ahead    (ahead)
    );

    // Update of the list state for the current beat.
    assign take      = present && (pos_reg < PW'(MAX_DEVICES));
    assign is_batt   = (dev.kind == cfg.battery_kind_code) || (dev.kind == cfg.ups_kind_code);
    assign is_active = (dev.state == cfg.charging_code) || (dev.state == cfg.discharging_code);

    always_comb begin
        have_upd     = have_reg;
        best_pos_upd = best_pos_reg;
        best_upd     = best_reg;
        pos_upd      = pos_reg;
        batt_upd     = batt_reg;
        act_upd      = act_reg;
        if (take) begin
            if (!have_reg || ahead) begin
                have_upd     = 1'b1;
                best_pos_upd = pos_reg[BPW-1:0];
                best_upd     = dev;
            end
            if (is_batt) begin
                batt_upd = batt_reg + 1'b1;
                if (is_active) begin
                    act_upd = act_reg + 1'b1;
                end
            end
            pos_upd = pos_reg + 1'b1;
        end
    end

    // The last beat of a list clears the state after forming the result.
    always_comb begin
        have_next     = have_reg;
        best_pos_next = best_pos_reg;
        best_next     = best_reg;
        pos_next      = pos_reg;
        batt_next     = batt_reg;
        act_next      = act_reg;
        if (step) begin
            if (last) begin
                have_next     = 1'b0;
                best_pos_next = '0;
                best_next     = '0;
                pos_next      = '0;
                batt_next     = '0;
                act_next      = '0;
            end else begin
                have_next     = have_upd;
                best_pos_next = best_pos_upd;
                best_next     = best_upd;
                pos_next      = pos_upd;
                batt_next     = batt_upd;
                act_next      = act_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg     <= 1'b0;
            best_pos_reg <= '0;
            best_reg     <= '0;
            pos_reg      <= '0;
            batt_reg     <= '0;
            act_reg      <= '0;
        end else begin
            have_reg     <= have_next;
            best_pos_reg <= best_pos_next;
            best_reg     <= best_next;
            pos_reg      <= pos_next;
            batt_reg     <= batt_next;
            act_reg      <= act_next;
        end
    end

    // Result fields from the updated state.
    assign level_round = {1'b0, best_upd.level} + LEVEL_HALF;
    assign level_full  = level_round[15:8];
    assign pos_ext     = {4'd0, best_pos_upd};
    assign batt_ext    = {5'd0, batt_upd};
    assign act_ext     = {5'd0, act_upd};

    always_comb begin
        result.primary_valid = have_upd;
        result.primary_index = have_upd ? pos_ext[3:0] : 4'd0;
        if (!have_upd) begin
            result.level_percent = 7'd0;
        end else if (level_full > {1'b0, LEVEL_MAX}) begin
            result.level_percent = LEVEL_MAX;
        end else begin
            result.level_percent = level_full[6:0];
        end
        case (cfg.icon_policy)
            POLICY_PRESENT: result.icon_visible = (batt_upd != '0);
            POLICY_ACTIVE:  result.icon_visible = (act_upd != '0);
            POLICY_NEVER:   result.icon_visible = 1'b0;
            default:        result.icon_visible = 1'b1;
        endcase
        result.battery_count = batt_ext[4:0];
        result.active_count  = act_ext[4:0];
    end

endmodule

### hdl/primary_power_source_select_unit.sv
// Top level of the primary power source selector.
`timescale 1ns / 1ps
//
// Usage: device records arrive as beats on the s_ channel, one record per beat,
// and s_tlast marks the final beat of a device list. s_tuser says whether the
// beat carries a device; an empty beat with s_tlast still closes the list.
// Each list yields one result beat on the m_ channel with the primary device
// index, its charge rounded to whole percent, the icon visibility and tallies.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while idle.
// The closing beat is held in the input register and its result is then captured in the
// result register, which presents the result beat on the m_ channel.
// Throughput: one beat per cycle unless a closing beat waits; the ranking compare against
// the held best device and the tally update fit between the input register and the state.
// When the m_ side stalls, the input register still takes beats that do not
// close a list; a closing beat waits in the input register until the result
// register frees, and s_tready stays low while it waits.
// Reset (aresetn low, synchronous) empties both registers, clears the list
// state and restores the configuration defaults.
//
module primary_power_source_select_unit #(
    parameter int MAX_DEVICES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // state[3:0], kind[8:4], time_estimate[40:9], charge_level[55:41]
    input  logic [ppss_pkg::S_DATA_W-1:0]     s_tdata,
    // device_present[0]
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // primary_index[3:0], level_percent[10:4], icon_visible[11],
    // battery_count[16:12], active_count[21:17], zero fill[23:22]
    output logic [ppss_pkg::M_DATA_W-1:0]     m_tdata,
    // primary_valid[0]
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [ppss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppss_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ppss_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    in_valid_reg, in_valid_next;
    logic    in_present_reg;
    logic    in_last_reg;
    dev_t    in_dev_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t result;
    logic    advance;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ICON_POLICY: cfg_next.icon_policy          = cfg_wdata[1:0];
                REG_CHARGING:    cfg_next.charging_code        = cfg_wdata[3:0];
                REG_DISCHARGING: cfg_next.discharging_code     = cfg_wdata[3:0];
                REG_BATTERY:     cfg_next.battery_kind_code    = cfg_wdata;
                REG_UPS:         cfg_next.ups_kind_code        = cfg_wdata;
                REG_LINE_POWER:  cfg_next.line_power_kind_code = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // A held beat moves on unless it closes a list while the result waits.
    assign advance  = in_valid_reg && !(in_last_reg && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    ppss_track #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (advance),
        .present (in_present_reg),
        .last    (in_last_reg),
        .dev     (in_dev_reg),
        .result  (result)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the input and result stages.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
            in_dev_reg     <= dev_t'(s_tdata);
        end
        if (advance && in_last_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.primary_valid;
    assign m_tdata  = {2'b00, out_reg.active_count, out_reg.battery_count,
                       out_reg.icon_visible, out_reg.level_percent, out_reg.primary_index};

endmodule

### hdl/ppss_checker.sv
// Port-level checker of the power source selector and its bind.
`timescale 1ns / 1ps
`include "primary_power_source_select_unit_defines.svh"

module ppss_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ppss_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import ppss_pkg::*;

    // A stalled result beat holds its payload.
    `PPSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Rounded level never exceeds one hundred percent.
    `PPSS_ASSERT_IMPL(a_level_range, m_tvalid, m_tdata[10:4] <= LEVEL_MAX)

    // Active devices are a subset of the batteries.
    `PPSS_ASSERT_IMPL(a_active_le_batt, m_tvalid, m_tdata[21:17] <= m_tdata[16:12])

    // A list without devices reports index and level as zero.
    `PPSS_ASSERT_IMPL(a_empty_zero, m_tvalid && !m_tuser, m_tdata[3:0] == 4'd0 && m_tdata[10:4] == 7'd0)

    // A closing beat is followed by a valid result beat.
    `PPSS_ASSERT_LAT2(a_result_latency, s_tvalid && s_tready && s_tlast, m_tvalid)

endmodule

bind primary_power_source_select_unit ppss_checker u_ppss_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench of the primary power source selector with its own list predictor.
`timescale 1ns / 1ps

module testbench;
    import ppss_pkg::*;

    localparam int DEVICE_LIMIT = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int REPORT_CAP = 40;
    // Policy code outside the documented set; the block shows the icon for it.
    localparam logic [1:0] POLICY_ALWAYS = 2'd3;

    // Predicts the summary beat of each device list and checks the block's beats.
    class source_tracker;
        logic [1:0] policy;
        logic [3:0] chg_code;
        logic [3:0] dis_code;
        logic [4:0] bat_kind;
        logic [4:0] ups_kind;
        logic [4:0] line_kind;
        bit holding;
        logic [3:0] lead_pos;
        dev_t lead;
        int unsigned seen;
        int unsigned batteries;
        int unsigned active;
        bit dropped;
        result_t pending_summaries[$];
        int unsigned mismatches;
        int unsigned lists_closed;
        int unsigned records_taken;
        int unsigned overflow_lists;

        function new();
            policy = CFG_RESET.icon_policy;
            chg_code = CFG_RESET.charging_code;
            dis_code = CFG_RESET.discharging_code;
            bat_kind = CFG_RESET.battery_kind_code;
            ups_kind = CFG_RESET.ups_kind_code;
            line_kind = CFG_RESET.line_power_kind_code;
            mismatches = 0;
            lists_closed = 0;
            records_taken = 0;
            overflow_lists = 0;
            clear_list();
        endfunction

        function void clear_list();
            holding = 1'b0;
            lead_pos = '0;
            lead = '0;
            seen = 0;
            batteries = 0;
            active = 0;
            dropped = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ICON_POLICY: policy = val[1:0];
                REG_CHARGING:    chg_code = val[3:0];
                REG_DISCHARGING: dis_code = val[3:0];
                REG_BATTERY:     bat_kind = val;
                REG_UPS:         ups_kind = val;
                REG_LINE_POWER:  line_kind = val;
                default: ;
            endcase
        endfunction

        // Line power takes precedence over the battery match when both codes coincide.
        function int weight_of(logic [4:0] kind);
            if (kind == line_kind) return WEIGHT_LINE;
            if (kind == bat_kind) return WEIGHT_BATTERY;
            return WEIGHT_OTHER;
        endfunction

        // True when the new record n strictly beats the held record h.
        function bit outranks(dev_t n, dev_t h);
            bit nd, hd, nc, hc;
            int wn, wh;
            nd = (n.state == dis_code);
            hd = (h.state == dis_code);
            nc = (n.state == chg_code);
            hc = (h.state == chg_code);
            if (nd || hd) begin
                if (!nd) return 1'b0;
                if (!hd) return 1'b1;
                if (n.time_est == 0 || h.time_est == 0) return n.time_est != 0;
                if (n.time_est != h.time_est) return n.time_est < h.time_est;
                return n.level < h.level;
            end
            if ((nc && n.time_est != 0) || (hc && h.time_est != 0)) begin
                if (!nc) return 1'b0;
                if (!hc) return 1'b1;
                if (n.time_est == 0 || h.time_est == 0) return n.time_est != 0;
                if (n.time_est != h.time_est) return n.time_est > h.time_est;
                return n.level < h.level;
            end
            wn = weight_of(n.kind);
            wh = weight_of(h.kind);
            if (wn != wh) return wn > wh;
            return n.state < h.state;
        endfunction

        // Updates the list state for one accepted beat; a closing beat queues a summary.
        function void take_device(bit present, dev_t d, bit last);
            result_t r;
            logic [15:0] lvl;
            if (present) begin
                if (seen < DEVICE_LIMIT) begin
                    if (!holding || outranks(d, lead)) begin
                        holding = 1'b1;
                        lead = d;
                        lead_pos = seen[3:0];
                    end
                    if (d.kind == bat_kind || d.kind == ups_kind) begin
                        batteries++;
                        if (d.state == chg_code || d.state == dis_code) active++;
                    end
                    seen++;
                    records_taken++;
                end else begin
                    dropped = 1'b1;
                end
            end
            if (last) begin
                lvl = 0;
                if (holding) begin
                    lvl = ({1'b0, lead.level} + 16'd128) >> 8;
                    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
                end
                r.primary_valid = holding;
                r.primary_index = holding ? lead_pos : 4'd0;
                r.level_percent = lvl[6:0];
                case (policy)
                    POLICY_PRESENT: r.icon_visible = (batteries > 0);
                    POLICY_ACTIVE:  r.icon_visible = (active > 0);
                    POLICY_NEVER:   r.icon_visible = 1'b0;
                    default:        r.icon_visible = 1'b1;
                endcase
                r.battery_count = batteries[4:0];
                r.active_count = active[4:0];
                pending_summaries.push_back(r);
                lists_closed++;
                if (dropped) overflow_lists++;
                clear_list();
            end
        endfunction

        function void compare_field(string label, int want, int got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, label, want, got);
            end
        endfunction

        // Checks one result beat against the oldest queued summary.
        function void check_summary(result_t got);
            result_t want;
            if (pending_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: result beat with none expected, expected none, actual %h",
                             $time, got);
                return;
            end
            want = pending_summaries.pop_front();
            compare_field("primary_valid", want.primary_valid, got.primary_valid);
            compare_field("primary_index", want.primary_index, got.primary_index);
            compare_field("level_percent", want.level_percent, got.level_percent);
            compare_field("icon_visible", want.icon_visible, got.icon_visible);
            compare_field("battery_count", want.battery_count, got.battery_count);
            compare_field("active_count", want.active_count, got.active_count);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    source_tracker tracker = new();
    bit no_idle = 1'b0;
    int ready_left = 0;
    int unsigned cycles = 0;
    int unsigned settings_used = 0;

    primary_power_source_select_unit #(
        .MAX_DEVICES(DEVICE_LIMIT)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run-length guard against a hung handshake.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_span();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure: alternating ready runs and stalls.
    always @(posedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            ready_left = idle_span();
        end else begin
            m_tready <= 1'b1;
            ready_left = $urandom_range(0, 20);
        end
    end

    // Result beat monitor.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.primary_valid = m_tuser;
            got.primary_index = m_tdata[3:0];
            got.level_percent = m_tdata[10:4];
            got.icon_visible = m_tdata[11];
            got.battery_count = m_tdata[16:12];
            got.active_count = m_tdata[21:17];
            tracker.check_summary(got);
        end
    end

    function automatic dev_t record_of(logic [3:0] st, logic [4:0] kind, logic [31:0] est,
                                       logic [14:0] lv);
        dev_t d;
        d.state = st;
        d.kind = kind;
        d.time_est = est;
        d.level = lv;
        return d;
    endfunction

    // Random record biased toward the configured state and kind codes.
    function automatic dev_t random_record();
        dev_t d;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) d.state = tracker.dis_code;
        else if (r < 7) d.state = tracker.chg_code;
        else d.state = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        if (r < 3) d.kind = tracker.bat_kind;
        else if (r < 5) d.kind = tracker.ups_kind;
        else if (r < 7) d.kind = tracker.line_kind;
        else d.kind = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 9);
        if (r < 3) d.time_est = 32'd0;
        else if (r < 6) d.time_est = $urandom_range(1, 4);
        else if (r < 7) d.time_est = 32'hFFFF_FFFF;
        else d.time_est = $urandom;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            d.level = 15'($urandom_range(0, 25600));
        end else if (r < 8) begin
            d.level = 15'($urandom_range(0, 32767));
        end else begin
            case ($urandom_range(0, 4))
                0: d.level = 15'd0;
                1: d.level = 15'd127;
                2: d.level = 15'd128;
                3: d.level = 15'd25600;
                default: d.level = 15'd32767;
            endcase
        end
        return d;
    endfunction

    // Presents one beat, starting and ending at a rising edge; notes it once taken.
    task automatic push_beat(input bit present, input dev_t d, input bit last);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= present;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_device(present, d, last);
    endtask

    task automatic push_device(input logic [3:0] st, input logic [4:0] kind,
                               input logic [31:0] est, input logic [14:0] lv, input bit last);
        push_beat(1'b1, record_of(st, kind, est, lv), last);
    endtask

    // Drops valid and waits until every summary is back and the pipeline is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending_summaries.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Back-to-back register writes with the enable held high throughout.
    task automatic apply_settings(input cfg_t c);
        write_reg(REG_ICON_POLICY, {3'b000, c.icon_policy});
        write_reg(REG_CHARGING, {1'b0, c.charging_code});
        write_reg(REG_DISCHARGING, {1'b0, c.discharging_code});
        write_reg(REG_BATTERY, c.battery_kind_code);
        write_reg(REG_UPS, c.ups_kind_code);
        write_reg(REG_LINE_POWER, c.line_power_kind_code);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Extremes first, then random settings.
    function automatic cfg_t settings_for(int phase);
        cfg_t c;
        case (phase)
            0: begin
                c = CFG_RESET;
                c.icon_policy = POLICY_ACTIVE;
            end
            1: c = '0;
            2: c = '{POLICY_ALWAYS, 4'd15, 4'd14, 5'd31, 5'd31, 5'd30};
            3: c = '{POLICY_NEVER, 4'd0, 4'd15, 5'd31, 5'd0, 5'd31};
            default: begin
                c.icon_policy = 2'($urandom_range(0, 3));
                c.charging_code = 4'($urandom_range(0, 15));
                c.discharging_code = 4'($urandom_range(0, 15));
                c.battery_kind_code = 5'($urandom_range(0, 31));
                c.ups_kind_code = 5'($urandom_range(0, 31));
                c.line_power_kind_code = 5'($urandom_range(0, 31));
            end
        endcase
        return c;
    endfunction

    // Random device lists: mostly short, some empty, a few past the device limit.
    task automatic random_lists(input int target);
        int taken, len, r;
        bit present;
        taken = 0;
        while (taken < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) len = $urandom_range(DEVICE_LIMIT + 1, DEVICE_LIMIT + 4);
            else if (r < 15) len = 1;
            else len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                present = (r >= 8 && r < 15) ? 1'b0 : ($urandom_range(0, 9) != 0);
                push_beat(present, random_record(), i == len - 1);
                taken++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lists under the reset settings.
        // A list made of one empty marker only.
        push_beat(1'b0, record_of(4'd0, 5'd0, 32'd0, 15'd0), 1'b1);
        // Discharging beats charging and idle; a known time beats an unknown one;
        // an identical later record keeps the earlier one.
        push_device(4'd0, 5'd1, 32'd0, 15'd0, 1'b0);
        push_device(4'd1, 5'd2, 32'hFFFF_FFFF, 15'd25600, 1'b0);
        push_device(4'd2, 5'd3, 32'd0, 15'd32767, 1'b0);
        push_beat(1'b0, record_of(4'd15, 5'd31, 32'hFFFF_FFFF, 15'h7FFF), 1'b0);
        push_device(4'd2, 5'd2, 32'd1, 15'd128, 1'b0);
        push_device(4'd2, 5'd2, 32'd1, 15'd128, 1'b1);
        // Neither side known-active: kind weight, then state; level above full scale.
        push_device(4'd15, 5'd31, 32'd0, 15'd127, 1'b0);
        push_device(4'd1, 5'd0, 32'd0, 15'd127, 1'b0);
        push_device(4'd0, 5'd2, 32'd0, 15'd32767, 1'b0);
        push_device(4'd3, 5'd1, 32'd0, 15'd5, 1'b1);
        // Charging: longer time wins, equal times fall back to the lower level.
        push_device(4'd1, 5'd3, 32'd100, 15'd5000, 1'b0);
        push_device(4'd1, 5'd3, 32'd200, 15'd6000, 1'b0);
        push_device(4'd1, 5'd3, 32'd200, 15'd5999, 1'b0);
        push_device(4'd1, 5'd2, 32'd0, 15'd1, 1'b1);
        settle();

        // Random phases, each under its own settings; one phase runs without idling.
        for (int phase = 0; phase < 7; phase++) begin
            apply_settings(settings_for(phase));
            no_idle = (phase == 2);
            random_lists(ITEMS_PER_PHASE);
            settle();
            no_idle = 1'b0;
        end
        repeat (10) @(posedge aclk);

        $display("Checked %0d device lists (%0d over the device limit), %0d devices taken,",
                 tracker.lists_closed, tracker.overflow_lists, tracker.records_taken);
        $display("under reset settings and %0d written register sets.", settings_used);
        if (tracker.mismatches == 0 && tracker.pending_summaries.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
